// ----- hw/rtl/dmlc_pkg.sv -----
`default_nettype none

package dmlc_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int LINE_BYTES = 16;

	// field widths
	localparam int ADDR_W  = 32;
	localparam int SIDX_W  = 8;
	localparam int OFF_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 5;
	localparam int TSLOT_W = 6;

	localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int BYTE_DEPTH = NUM_SLOTS * LINE_BYTES;
	localparam int BADDR_W    = (BYTE_DEPTH > 1) ? $clog2(BYTE_DEPTH) : 1;
	localparam int INFO_W     = ADDR_W + SIZE_W;

	// slot and offset are bit fields of the address, both sizes are powers of two
	localparam int LOG_LB = $clog2(LINE_BYTES);

	localparam int IN_W  = 64;
	localparam int OUT_W = 56;

	typedef enum logic [1:0] {
		K_READ  = 2'd0,
		K_FILL  = 2'd1,
		K_CLEAR = 2'd2,
		K_QUERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_MISS  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/direct_mapped_line_cache.sv -----
`default_nettype none

// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tuser kind, s_tdata address..fill_size
// m_*       out  m_tvalid/m_tready   m_tuser status, m_tdata hit..line_valid
//
// one request at a time: the rams are read in S_RD and the result is registered on leaving
// S_RESP; a new request is taken in S_IDLE only after the last result has been loaded.
// the slot info ram and the line byte ram are read once per request, written by a fill.
// reset and clear zero the valid bits in flops; no clearing pass.
// a result waiting on m_tready holds the next request in S_RESP with s_tready low
// until that request's result can be loaded.
module direct_mapped_line_cache (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// address, slot_index, byte_offset, fill_byte, fill_size, zero pad
	input  wire logic [dmlc_pkg::IN_W-1:0] s_tdata,
	// kind
	input  wire logic [1:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// hit, read_data, target_slot, line_base, line_size, line_valid, zero pad
	output logic [dmlc_pkg::OUT_W-1:0]     m_tdata,
	// status
	output logic [1:0]                     m_tuser
);

	import dmlc_pkg::*;

	state_t state_q, state_d;
	logic   load;
	logic   accept;

	logic [ADDR_W-1:0] addr_in;
	logic [SIDX_W-1:0] sidx_in;
	kind_t             kind_in;
	logic [SLOT_W-1:0] slot_fast;
	logic [OFF_W-1:0]  off_fast;

	kind_t             kind_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIDX_W-1:0] sidx_q;
	logic [OFF_W-1:0]  boff_q;
	logic [BYTE_W-1:0] fbyte_q;
	logic [SIZE_W-1:0] fsize_q;
	logic [SLOT_W-1:0] slot_q;
	logic [OFF_W-1:0]  off_q;

	logic [NUM_SLOTS-1:0] valid_q;

	logic [BADDR_W-1:0] line_addr, byte_raddr, byte_waddr;
	logic               rd_en;
	logic               info_we, byte_we;
	logic [INFO_W-1:0]  info_rd;
	logic [BYTE_W-1:0]  byte_rd;
	logic [SIZE_W-1:0]  fsize_sat;
	logic [ADDR_W-1:0]  base_new;

	logic              cur_valid;
	logic [ADDR_W-1:0] cur_base;
	logic [SIZE_W-1:0] cur_size;
	logic              is_hit;
	logic              in_range;

	logic               res_hit;
	logic [BYTE_W-1:0]  res_data;
	logic [TSLOT_W-1:0] res_tslot;
	logic [ADDR_W-1:0]  res_base;
	logic [SIZE_W-1:0]  res_size;
	logic               res_valid;
	status_t            res_status;

	logic               out_valid_q;
	logic               out_hit_q;
	logic [BYTE_W-1:0]  out_data_q;
	logic [TSLOT_W-1:0] out_tslot_q;
	logic [ADDR_W-1:0]  out_base_q;
	logic [SIZE_W-1:0]  out_size_q;
	logic               out_lvalid_q;
	status_t            out_status_q;

	assign addr_in   = s_tdata[31:0];
	assign sidx_in   = s_tdata[39:32];
	assign kind_in   = kind_t'(s_tuser);
	assign slot_fast = SLOT_W'((addr_in >> LOG_LB) & ADDR_W'(NUM_SLOTS - 1));
	assign off_fast  = OFF_W'(addr_in & ADDR_W'(LINE_BYTES - 1));
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || m_tready) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			valid_q     <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (load && kind_q == K_CLEAR) begin
				valid_q <= '0;
			end else if (load && kind_q == K_FILL) begin
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind_in;
			addr_q  <= addr_in;
			sidx_q  <= sidx_in;
			boff_q  <= s_tdata[43:40];
			fbyte_q <= s_tdata[51:44];
			fsize_q <= s_tdata[56:52];
			off_q   <= off_fast;
			if (kind_in == K_QUERY) begin
				slot_q <= SLOT_W'(sidx_in);
			end else begin
				slot_q <= slot_fast;
			end
		end
		if (load) begin
			out_hit_q    <= res_hit;
			out_data_q   <= res_data;
			out_tslot_q  <= res_tslot;
			out_base_q   <= res_base;
			out_size_q   <= res_size;
			out_lvalid_q <= res_valid;
			out_status_q <= res_status;
		end
	end

	assign rd_en      = state_q == S_RD;
	assign line_addr  = BADDR_W'(slot_q) * BADDR_W'(LINE_BYTES);
	assign byte_raddr = line_addr + BADDR_W'((kind_q == K_QUERY) ? boff_q : off_q);
	assign byte_waddr = line_addr + BADDR_W'(boff_q);
	assign fsize_sat  = (fsize_q > SIZE_W'(LINE_BYTES)) ? SIZE_W'(LINE_BYTES) : fsize_q;
	assign base_new   = addr_q - ADDR_W'(off_q);
	assign info_we    = load && kind_q == K_FILL;
	assign byte_we    = info_we && ({1'b0, boff_q} < fsize_sat);

	dmlc_ram #(
		.WIDTH (INFO_W),
		.DEPTH (NUM_SLOTS)
	) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (slot_q),
		.wdata ({base_new, fsize_sat}),
		.re    (rd_en),
		.raddr (slot_q),
		.rdata (info_rd)
	);

	dmlc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (BYTE_DEPTH)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (fbyte_q),
		.re    (rd_en),
		.raddr (byte_raddr),
		.rdata (byte_rd)
	);

	// an invalid slot reads as cleared info
	assign cur_valid = valid_q[slot_q];
	assign cur_base  = cur_valid ? info_rd[INFO_W-1:SIZE_W] : '0;
	assign cur_size  = cur_valid ? info_rd[SIZE_W-1:0] : '0;
	assign is_hit    = cur_valid && (addr_q >= cur_base) &&
		((addr_q - cur_base) < ADDR_W'(cur_size));
	assign in_range  = {1'b0, sidx_q} < (SIDX_W + 1)'(NUM_SLOTS);

	always_comb begin
		res_hit    = 1'b0;
		res_data   = '0;
		res_tslot  = TSLOT_W'(slot_q);
		res_base   = cur_base;
		res_size   = cur_size;
		res_valid  = cur_valid;
		res_status = STAT_OK;
		case (kind_q)
			K_READ: begin
				res_hit = is_hit;
				if (is_hit) begin
					res_data = byte_rd;
				end else begin
					res_status = STAT_MISS;
				end
			end
			K_FILL: begin
				res_base  = base_new;
				res_size  = fsize_sat;
				res_valid = 1'b1;
			end
			K_CLEAR: begin
				res_tslot = '0;
				res_base  = '0;
				res_size  = '0;
				res_valid = 1'b0;
			end
			K_QUERY: begin
				if (!in_range) begin
					res_tslot  = '0;
					res_base   = '0;
					res_size   = '0;
					res_valid  = 1'b0;
					res_status = STAT_RANGE;
				end else if ({1'b0, boff_q} < cur_size) begin
					res_data = byte_rd;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_lvalid_q, out_size_q, out_base_q, out_tslot_q,
		out_data_q, out_hit_q};
	assign m_tuser  = out_status_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dmlc_ram.sv -----
`default_nettype none

module dmlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- verif/cache_checker.sv -----
`default_nettype none

module cache_checker import dmlc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic [1:0]       s_tuser,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	input  wire logic [1:0]       m_tuser,
	output int                    failures,
	output int                    pending
);

	typedef struct packed {
		logic               hit;
		logic [BYTE_W-1:0]  read_data;
		logic [TSLOT_W-1:0] target_slot;
		logic [ADDR_W-1:0]  line_base;
		logic [SIZE_W-1:0]  line_size;
		logic               line_valid;
		status_t            status;
	} cache_result_t;

	cache_result_t     expected_q[$];
	logic              slot_valid[NUM_SLOTS];
	logic [ADDR_W-1:0] slot_base[NUM_SLOTS];
	logic [SIZE_W-1:0] slot_size[NUM_SLOTS];
	logic [BYTE_W-1:0] line_mem[BYTE_DEPTH];

	task automatic report_mismatch(input string what, input logic [31:0] got_val,
			input logic [31:0] exp_val);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got_val, exp_val);
		failures++;
	endtask

	function automatic cache_result_t slot_info(input int unsigned s);
		cache_result_t r;
		r = '0;
		r.target_slot = TSLOT_W'(s);
		r.line_base   = slot_base[s];
		r.line_size   = slot_size[s];
		r.line_valid  = slot_valid[s];
		return r;
	endfunction

	// updates the cache image and returns the result the request should produce
	function automatic cache_result_t cache_access(input kind_t kind,
			input logic [ADDR_W-1:0] addr, input logic [SIDX_W-1:0] sidx,
			input logic [OFF_W-1:0] boff, input logic [BYTE_W-1:0] fbyte,
			input logic [SIZE_W-1:0] fsize);
		cache_result_t r;
		int unsigned   s;
		logic [31:0]   off;
		int unsigned   fsat;
		r = '0;
		case (kind)
			K_READ: begin
				s = (addr / LINE_BYTES) % NUM_SLOTS;
				off = addr - slot_base[s];
				r = slot_info(s);
				if (slot_valid[s] && addr >= slot_base[s] && off < slot_size[s]) begin
					r.hit = 1'b1;
					r.read_data = line_mem[s * LINE_BYTES + off];
					r.status = STAT_OK;
				end else begin
					r.status = STAT_MISS;
				end
			end
			K_FILL: begin
				s = (addr / LINE_BYTES) % NUM_SLOTS;
				fsat = (fsize > LINE_BYTES) ? LINE_BYTES : fsize;
				slot_valid[s] = 1'b1;
				slot_base[s] = (addr / LINE_BYTES) * LINE_BYTES;
				slot_size[s] = SIZE_W'(fsat);
				// offsets past the line size leave the byte store alone
				if (boff < fsat)
					line_mem[s * LINE_BYTES + boff] = fbyte;
				r = slot_info(s);
				r.status = STAT_OK;
			end
			K_CLEAR: begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					slot_valid[i] = 1'b0;
					slot_base[i] = '0;
					slot_size[i] = '0;
				end
				r.status = STAT_OK;
			end
			default: begin
				if (sidx >= NUM_SLOTS) begin
					r.status = STAT_RANGE;
				end else begin
					r = slot_info(sidx);
					if (boff < slot_size[sidx])
						r.read_data = line_mem[sidx * LINE_BYTES + boff];
					r.status = STAT_OK;
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		cache_result_t got;
		cache_result_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_valid[i] = 1'b0;
				slot_base[i] = '0;
				slot_size[i] = '0;
			end
			expected_q.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(cache_access(kind_t'(s_tuser), s_tdata[31:0],
					s_tdata[39:32], s_tdata[43:40], s_tdata[51:44], s_tdata[56:52]));
			if (m_tvalid && m_tready) begin
				got.hit         = m_tdata[0];
				got.read_data   = m_tdata[8:1];
				got.target_slot = m_tdata[14:9];
				got.line_base   = m_tdata[46:15];
				got.line_size   = m_tdata[51:47];
				got.line_valid  = m_tdata[52];
				got.status      = status_t'(m_tuser);
				if (expected_q.size() == 0) begin
					report_mismatch("unrequested result", m_tdata[31:0], '0);
				end else begin
					exp_r = expected_q.pop_front();
					if (got.hit !== exp_r.hit)
						report_mismatch("hit", 32'(got.hit), 32'(exp_r.hit));
					if (got.read_data !== exp_r.read_data)
						report_mismatch("read_data", 32'(got.read_data), 32'(exp_r.read_data));
					if (got.target_slot !== exp_r.target_slot)
						report_mismatch("target_slot", 32'(got.target_slot),
							32'(exp_r.target_slot));
					if (got.line_base !== exp_r.line_base)
						report_mismatch("line_base", got.line_base, exp_r.line_base);
					if (got.line_size !== exp_r.line_size)
						report_mismatch("line_size", 32'(got.line_size), 32'(exp_r.line_size));
					if (got.line_valid !== exp_r.line_valid)
						report_mismatch("line_valid", 32'(got.line_valid),
							32'(exp_r.line_valid));
					if (got.status !== exp_r.status)
						report_mismatch("status", 32'(got.status), 32'(exp_r.status));
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;
	import dmlc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TOTAL_REQ   = 775;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic [1:0]       s_tuser = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0]       m_tuser;
	int               failures;
	int               pending;
	int               cycles = 0;
	int               sent = 0;
	int               send_idle_pct = 8;
	int               recv_idle_pct = 70;

	// what the stimulus knows of the cache, so that no unwritten byte is ever read
	logic              shadow_valid[NUM_SLOTS];
	logic [ADDR_W-1:0] shadow_base[NUM_SLOTS];
	logic [SIZE_W-1:0] shadow_size[NUM_SLOTS];
	logic              byte_written[BYTE_DEPTH];
	logic [21:0]       tag_pool[4];

	direct_mapped_line_cache dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cache_checker result_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.failures (failures),
		.pending  (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[direct_mapped_line_cache] ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic int unsigned slot_of(input logic [ADDR_W-1:0] a);
		return (a / LINE_BYTES) % NUM_SLOTS;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_line();
		return {tag_pool[$urandom_range(3)], 6'($urandom_range(63)), 4'b0};
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return SIZE_W'($urandom_range(31, 17));
		return SIZE_W'($urandom_range(16, 1));
	endfunction

	task automatic send_request(input kind_t kind, input logic [ADDR_W-1:0] addr,
			input logic [SIDX_W-1:0] sidx, input logic [OFF_W-1:0] boff,
			input logic [BYTE_W-1:0] fbyte, input logic [SIZE_W-1:0] fsize);
		int unsigned s;
		logic [31:0] off;
		int unsigned fsat;
		// a request that would hit an unwritten byte becomes the fill beat for it
		if (kind == K_READ) begin
			s = slot_of(addr);
			off = addr - shadow_base[s];
			if (shadow_valid[s] && addr >= shadow_base[s] && off < shadow_size[s] &&
					!byte_written[s * LINE_BYTES + off]) begin
				kind = K_FILL;
				addr = shadow_base[s];
				boff = off[3:0];
				fsize = shadow_size[s];
				fbyte = BYTE_W'($urandom);
			end
		end else if (kind == K_QUERY && sidx < NUM_SLOTS) begin
			if (boff < shadow_size[sidx] && !byte_written[sidx * LINE_BYTES + boff]) begin
				kind = K_FILL;
				addr = shadow_base[sidx];
				fsize = shadow_size[sidx];
				fbyte = BYTE_W'($urandom);
			end
		end
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= IN_W'({fsize, fbyte, boff, sidx, addr});
		do @(posedge clk); while (!s_tready);
		if (kind == K_FILL) begin
			s = slot_of(addr);
			fsat = (fsize > LINE_BYTES) ? LINE_BYTES : fsize;
			shadow_valid[s] = 1'b1;
			shadow_base[s] = (addr / LINE_BYTES) * LINE_BYTES;
			shadow_size[s] = SIZE_W'(fsat);
			if (boff < fsat)
				byte_written[s * LINE_BYTES + boff] = 1'b1;
		end else if (kind == K_CLEAR) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				shadow_valid[i] = 1'b0;
				shadow_base[i] = '0;
				shadow_size[i] = '0;
			end
		end
		sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [ADDR_W-1:0] line;
		logic [ADDR_W-1:0] recent_line;
		logic [SIZE_W-1:0] fs;
		int unsigned       beats;
		int unsigned       start;
		int unsigned       choose;
		bit                drained;
		drained = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_base[i] = '0;
			shadow_size[i] = '0;
		end
		for (int i = 0; i < BYTE_DEPTH; i++)
			byte_written[i] = 1'b0;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		tag_pool[2] = 22'($urandom);
		tag_pool[3] = 22'($urandom);
		recent_line = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty cache, out-of-range and boundary queries
		send_request(K_READ, 32'h0000_0000, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_QUERY, 32'h0, 8'd255, 4'd0, 8'h00, 5'd0);
		send_request(K_QUERY, 32'h0, 8'd64, 4'd0, 8'h00, 5'd0);
		send_request(K_QUERY, 32'h0, 8'd63, 4'd15, 8'h00, 5'd0);
		// top line, oversized fill saturates
		send_request(K_FILL, 32'hFFFF_FFF0, 8'd0, 4'd15, 8'hFF, 5'd31);
		send_request(K_FILL, 32'hFFFF_FFFF, 8'd0, 4'd0, 8'h00, 5'd16);
		send_request(K_READ, 32'hFFFF_FFFF, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_READ, 32'hFFFF_FFF0, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_QUERY, 32'h0, 8'd63, 4'd15, 8'h00, 5'd0);
		// zero size line is valid but never hits
		send_request(K_FILL, 32'h0000_0000, 8'd0, 4'd0, 8'h11, 5'd0);
		send_request(K_READ, 32'h0000_0000, 8'd0, 4'd0, 8'h00, 5'd0);
		// short line with a beat past its size
		send_request(K_FILL, 32'h0000_0005, 8'd0, 4'd3, 8'h5A, 5'd3);
		send_request(K_FILL, 32'h0000_0001, 8'd0, 4'd0, 8'hA5, 5'd3);
		send_request(K_FILL, 32'h0000_0002, 8'd0, 4'd1, 8'h3C, 5'd3);
		send_request(K_FILL, 32'h0000_0000, 8'd0, 4'd2, 8'hC3, 5'd3);
		send_request(K_READ, 32'h0000_0002, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_READ, 32'h0000_0003, 8'd0, 4'd0, 8'h00, 5'd0);
		// conflicting tag above and below the stored base
		send_request(K_READ, 32'h0000_0400, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_READ, 32'h0000_03F0, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_CLEAR, 32'h0, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_READ, 32'hFFFF_FFFF, 8'd0, 4'd0, 8'h00, 5'd0);
		send_request(K_QUERY, 32'h0, 8'd63, 4'd0, 8'h00, 5'd0);

		while (sent < TOTAL_REQ) begin
			if (sent < 275) begin
				send_idle_pct = 8;
				recv_idle_pct = 70;
			end else if (sent < 525) begin
				send_idle_pct = 70;
				recv_idle_pct = 8;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (!drained && sent >= 400) begin
				drained = 1'b1;
				wait_drained();
			end
			choose = $urandom_range(99);
			if (choose < 55) begin
				// line fill burst, at times a beat past its size, then reads into the line and at times a query of its slot
				line = pick_line();
				fs = pick_size();
				beats = (fs > LINE_BYTES) ? LINE_BYTES : fs;
				start = $urandom_range(15);
				for (int i = 0; i < beats; i++)
					send_request(K_FILL, line | $urandom_range(15), 8'($urandom),
						4'((start + i) % beats), 8'($urandom), fs);
				if (beats < LINE_BYTES && $urandom_range(3) == 0)
					send_request(K_FILL, line, 8'($urandom),
						4'($urandom_range(15, beats)), 8'($urandom), fs);
				repeat ($urandom_range(4, 1))
					send_request(K_READ, line | $urandom_range(15), 8'($urandom),
						4'($urandom), 8'($urandom), 5'($urandom));
				if ($urandom_range(3) == 0)
					send_request(K_QUERY, 32'($urandom), 8'(slot_of(line)),
						4'($urandom), 8'($urandom), 5'($urandom));
				recent_line = line;
			end else if (choose < 80) begin
				line = $urandom_range(1) ? recent_line : pick_line();
				send_request(K_READ, line | $urandom_range(15), 8'($urandom),
					4'($urandom), 8'($urandom), 5'($urandom));
			end else if (choose < 90) begin
				send_request(K_QUERY, 32'($urandom),
					8'($urandom_range(3) != 0 ? $urandom_range(63) : $urandom_range(255)),
					4'($urandom), 8'($urandom), 5'($urandom));
			end else if (choose < 98) begin
				send_request(kind_t'($urandom_range(3)), 32'($urandom), 8'($urandom),
					4'($urandom), 8'($urandom), 5'($urandom));
			end else begin
				send_request(K_CLEAR, 32'($urandom), 8'($urandom), 4'($urandom),
					8'($urandom), 5'($urandom));
			end
		end

		wait_drained();
		// late or duplicate results would show up here
		repeat (16) @(posedge clk);
		if (failures == 0)
			$display("[direct_mapped_line_cache] OK");
		else
			$display("[direct_mapped_line_cache] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
